FILE: sv/dzls_pkg.sv
// Shared types and constants for the Z251 LCG sampler.
// Used by dzls_lcg and distinct_z251_lcg_sampler.
`default_nettype none

package dzls_pkg;

  localparam int LCG_W = 48;
  localparam int HALF_W = 24;

  localparam logic [LCG_W-1:0] LCG_MUL = 48'h0005_DEEC_E66D;
  localparam logic [LCG_W-1:0] LCG_ADD = 48'h0000_0000_000B;
  localparam logic [HALF_W-1:0] MUL_LO = LCG_MUL[HALF_W-1:0];
  localparam logic [HALF_W-1:0] MUL_HI = LCG_MUL[LCG_W-1:HALF_W];

  localparam logic [7:0] ZMOD = 8'd251;

  // request codes
  localparam logic [1:0] FN_RESEED = 2'd0;
  localparam logic [1:0] FN_SINGLE = 2'd1;
  localparam logic [1:0] FN_SET    = 2'd2;

  typedef struct packed {
    logic             start;
    logic             load;
    logic [LCG_W-1:0] seed;
  } lcg_ctl_t;

  typedef struct packed {
    logic       done;
    logic [7:0] draw;
  } lcg_sts_t;

endpackage

`default_nettype wire

FILE: sv/dzls_lcg.sv
// 48-bit LCG with one shared 24x24 multiplier, stepped through the states M0, M1, M2 and SUM.
// Depends on dzls_pkg for the constants and the control/status structs.
`default_nettype none

module dzls_lcg (
  input  wire                clk,
  input  wire                rst,
  input  wire dzls_pkg::lcg_ctl_t ctl,
  output dzls_pkg::lcg_sts_t sts
);
  import dzls_pkg::*;

  localparam logic [2:0] P_IDLE = 3'd0;
  localparam logic [2:0] P_M0   = 3'd1;
  localparam logic [2:0] P_M1   = 3'd2;
  localparam logic [2:0] P_M2   = 3'd3;
  localparam logic [2:0] P_SUM  = 3'd4;

  logic [2:0]        step;
  logic [LCG_W-1:0]  gen;
  logic [LCG_W-1:0]  acc;
  logic [LCG_W-1:0]  prod;
  logic              done;
  logic [HALF_W-1:0] mul_a;
  logic [HALF_W-1:0] mul_b;
  logic [LCG_W-1:0]  mul_out;

  // partial products: lo*lo, hi*lo, lo*hi; hi*hi falls off the top
  assign mul_a   = (step == P_M1) ? gen[LCG_W-1:HALF_W] : gen[HALF_W-1:0];
  assign mul_b   = (step == P_M2) ? MUL_HI : MUL_LO;
  assign mul_out = LCG_W'(mul_a) * LCG_W'(mul_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= P_IDLE;
      gen  <= LCG_MUL;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (step)
        P_IDLE: begin
          if (ctl.load) begin
            gen <= ctl.seed ^ LCG_MUL;
          end else if (ctl.start) begin
            step <= P_M0;
          end
        end
        P_M0:  step <= P_M1;
        P_M1:  step <= P_M2;
        P_M2:  step <= P_SUM;
        P_SUM: begin
          gen  <= acc + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
          done <= 1'b1;
          step <= P_IDLE;
        end
        default: step <= P_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_out;
    case (step)
      P_M1:    acc <= prod + LCG_ADD;
      P_M2:    acc <= acc + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
      default: acc <= acc;
    endcase
  end

  assign sts.done = done;
  assign sts.draw = gen[LCG_W-1:LCG_W-8];

endmodule

`default_nettype wire

FILE: sv/distinct_z251_lcg_sampler.sv
// Z251 sampler on a 48-bit LCG. A raw draw runs on the shared multiplier
// (start, four multiply/accumulate steps, done); draws of 251 or more repeat.
// A set value at index i adds one discarded draw and a scan of the i stored values per candidate
// through the set memory; one request is handled at a time, a reseed loads the generator from the seed register.
// Reset (synchronous): generator holds 0x5DEECE66D, seed register is zero, no output.
`default_nettype none

module distinct_z251_lcg_sampler #(
  parameter int MAX_COUNT = 64
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        cfg_write,
  input  wire [47:0] cfg_data,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire [1:0]  func,
  input  wire [6:0]  count,
  output logic       out_valid,
  input  wire        out_stall,
  output logic [7:0] value,
  output logic [5:0] position,
  output logic       last
);
  import dzls_pkg::*;

  localparam int CNT_W  = $clog2(MAX_COUNT + 1);
  localparam int ADDR_W = (MAX_COUNT > 1) ? $clog2(MAX_COUNT) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DRAW = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]        st;
  logic [LCG_W-1:0]  seed;
  logic [CNT_W-1:0]  n;
  logic [CNT_W-1:0]  i;
  logic [7:0]        cand;
  logic              discard;
  logic              lcg_start;
  logic [ADDR_W-1:0] scan_k;
  logic [7:0]        rd_data;
  logic              rd_valid;
  logic              rd_last;
  logic [7:0]        set_mem [MAX_COUNT];

  logic              in_take;
  logic              out_load;
  logic              is_last;
  logic [CNT_W-1:0]  n_sat;
  lcg_ctl_t          ctl;
  lcg_sts_t          sts;

  assign in_stall = (st != ST_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_load = (st == ST_EMIT) && (!out_valid || !out_stall);
  assign is_last  = ((i + CNT_W'(1)) == n);
  assign n_sat    = (32'(count) > MAX_COUNT) ? CNT_W'(MAX_COUNT) : CNT_W'(count);

  assign ctl.start = lcg_start;
  assign ctl.load  = in_take && (func == FN_RESEED);
  assign ctl.seed  = seed;

  dzls_lcg u_lcg (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .sts (sts)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      seed      <= '0;
      lcg_start <= 1'b0;
      discard   <= 1'b0;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      lcg_start <= 1'b0;
      if (cfg_write) begin
        seed <= cfg_data;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (st)
        ST_IDLE: begin
          if (in_take) begin
            i       <= '0;
            discard <= 1'b0;
            case (func)
              FN_SINGLE: begin
                n         <= CNT_W'(1);
                lcg_start <= 1'b1;
                st        <= ST_DRAW;
              end
              FN_SET: begin
                n <= n_sat;
                if (n_sat != '0) begin
                  lcg_start <= 1'b1;
                  st        <= ST_DRAW;
                end
              end
              default: st <= ST_IDLE;
            endcase
          end
        end
        ST_DRAW: begin
          if (sts.done) begin
            if (sts.draw >= ZMOD) begin
              lcg_start <= 1'b1;
            end else if (discard) begin
              // drop the extra draw taken ahead of each later set value
              discard   <= 1'b0;
              lcg_start <= 1'b1;
            end else begin
              cand <= sts.draw;
              if (i == '0) begin
                st <= ST_EMIT;
              end else begin
                scan_k   <= '0;
                rd_valid <= 1'b0;
                st       <= ST_SCAN;
              end
            end
          end
        end
        ST_SCAN: begin
          if (rd_valid && (rd_data == cand)) begin
            rd_valid  <= 1'b0;
            lcg_start <= 1'b1;
            st        <= ST_DRAW;
          end else if (rd_valid && rd_last) begin
            rd_valid <= 1'b0;
            st       <= ST_EMIT;
          end else begin
            rd_valid <= 1'b1;
            rd_last  <= (CNT_W'(scan_k) == (i - CNT_W'(1)));
            if (CNT_W'(scan_k) != (i - CNT_W'(1))) begin
              scan_k <= scan_k + ADDR_W'(1);
            end
          end
        end
        ST_EMIT: begin
          if (out_load) begin
            out_valid <= 1'b1;
            if (is_last) begin
              st <= ST_IDLE;
            end else begin
              i         <= i + CNT_W'(1);
              discard   <= 1'b1;
              lcg_start <= 1'b1;
              st        <= ST_DRAW;
            end
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  // output payload and set memory
  always_ff @(posedge clk) begin
    if (out_load) begin
      value              <= cand;
      position           <= 6'(i);
      last               <= is_last;
      set_mem[i[ADDR_W-1:0]] <= cand;
    end
    rd_data <= set_mem[scan_k];
  end

endmodule

`default_nettype wire
